>>> rtl/hsa_pkg.sv
// ----------------------------------------------------------------------------
// HSL saturation adjust package
// Shared constants, the sideband record and the output clamp.
// ----------------------------------------------------------------------------
package hsa_pkg;

  localparam int CH_W      = 8;
  localparam int SUM_W     = 9;
  localparam int STEP_W    = 9;
  localparam int SAT_W     = 17;
  localparam int ALPHA_W   = 24;
  localparam int ADIV_W    = 25;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic ADDR_STEP = 1'b0;

  localparam logic [SAT_W-1:0] Q16_ONE = 17'h10000;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             frame_end;
    logic             gray;
    logic [SUM_W-1:0] sum;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  function automatic logic [CH_W-1:0] clamp8(input logic signed [19:0] v);
    logic [CH_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > 20'sd255) begin
      res = 8'd255;
    end else begin
      res = v[CH_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/hsa_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, MSB first, with a sideband carried alongside.
// ----------------------------------------------------------------------------
module hsa_div #(
  parameter int DW = 9,
  parameter int QW = 17,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_in,
  input  logic [DW:0]   rem_in,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [QW-1:0] quotient,
  output logic [SW-1:0] side_out
);

  logic          v  [0:QW];
  logic [DW:0]   r  [0:QW];
  logic [DW-1:0] d  [0:QW];
  logic [QW-1:0] q  [0:QW];
  logic [SW-1:0] sd [0:QW];

  assign v[0]  = valid_in;
  assign r[0]  = rem_in;
  assign d[0]  = divisor;
  assign q[0]  = '0;
  assign sd[0] = side_in;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          ge;
    logic [DW:0]   sub;
    logic [DW-1:0] rn;
    logic [QW-1:0] qn;

    always_comb begin
      ge  = r[i] >= {1'b0, d[i]};
      sub = r[i] - {1'b0, d[i]};
      rn  = ge ? sub[DW-1:0] : r[i][DW-1:0];
      qn  = q[i];
      qn[QW-1-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        r[i+1]  <= {rn, 1'b0};
        d[i+1]  <= d[i];
        q[i+1]  <= qn;
        sd[i+1] <= sd[i];
      end
    end
  end

  assign valid_out = v[QW];
  assign quotient  = q[QW];
  assign side_out  = sd[QW];

endmodule

>>> rtl/hsa_mix.sv
// ----------------------------------------------------------------------------
// Channel mixer
// Forms alpha, multiplies each channel offset, truncates and clamps.
// ----------------------------------------------------------------------------
module hsa_mix (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         valid_in,
  input  logic [hsa_pkg::ADIV_W-1:0]   quot,
  input  logic signed [hsa_pkg::STEP_W-1:0] step,
  input  hsa_pkg::side_t               side_in,
  output logic                         valid_out,
  output logic [hsa_pkg::CH_W-1:0]     red,
  output logic [hsa_pkg::CH_W-1:0]     green,
  output logic [hsa_pkg::CH_W-1:0]     blue,
  output logic                         frame_end
);
  import hsa_pkg::*;

  logic               va;
  logic [ALPHA_W-1:0] alpha;
  side_t              sa;
  logic [ADIV_W-1:0]  asub;

  assign asub = quot - ADIV_W'(Q16_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= valid_in;
    end
    if (en) begin
      alpha <= asub[ALPHA_W-1:0];
      sa    <= side_in;
    end
  end

  logic [CH_W-1:0]   ch [0:2];
  logic signed [35:0] pos_c [0:2];
  logic signed [23:0] neg_c [0:2];
  logic signed [9:0]  f;

  assign ch[0] = sa.red;
  assign ch[1] = sa.green;
  assign ch[2] = sa.blue;
  assign f = $signed({step[STEP_W-1], step}) + 10'sd256;

  for (genvar k = 0; k < 3; k++) begin : g_prod
    logic signed [10:0] d2;
    assign d2 = $signed({2'b00, ch[k], 1'b0}) - $signed({2'b00, sa.sum});
    assign pos_c[k] = $signed({11'b0, ch[k], 17'b0})
                    + 36'(d2) * $signed({12'b0, alpha});
    assign neg_c[k] = $signed({7'b0, sa.sum, 8'b0}) + 24'(d2) * 24'(f);
  end

  logic               vp;
  logic               neg;
  side_t              sp;
  logic signed [35:0] pos_r [0:2];
  logic signed [23:0] neg_r [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= va;
    end
    if (en) begin
      neg <= step[STEP_W-1];
      sp  <= sa;
      for (int k = 0; k < 3; k++) begin
        pos_r[k] <= pos_c[k];
        neg_r[k] <= neg_c[k];
      end
    end
  end

  logic [CH_W-1:0] res [0:2];
  logic [CH_W-1:0] pch [0:2];

  assign pch[0] = sp.red;
  assign pch[1] = sp.green;
  assign pch[2] = sp.blue;

  for (genvar k = 0; k < 3; k++) begin : g_out
    logic signed [35:0] pt;
    logic signed [23:0] nt;
    always_comb begin
      pt = pos_r[k] < 0 ? (pos_r[k] + 36'sd131071) >>> 17 : pos_r[k] >>> 17;
      nt = neg_r[k] < 0 ? (neg_r[k] + 24'sd511) >>> 9 : neg_r[k] >>> 9;
      if (sp.gray) begin
        res[k] = pch[k];
      end else if (neg) begin
        res[k] = clamp8(20'(nt));
      end else begin
        res[k] = clamp8(pt[19:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= vp;
    end
    if (en) begin
      red       <= res[0];
      green     <= res[1];
      blue      <= res[2];
      frame_end <= sp.frame_end;
    end
  end

endmodule

>>> rtl/hsl_saturation_adjust.sv
// ----------------------------------------------------------------------------
// HSL saturation adjust
// Pushes or pulls each pixel's channels relative to its lightness.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and returns one adjusted word per
// clock unless its output stalls. Its 48 register stages are mostly the two
// bit-per-stage divider pipelines (17 stages for saturation, 25 for alpha).
// The whole pipeline holds while an output word waits, so nothing is lost or
// repeated.
module hsl_saturation_adjust (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hsa_pkg::ADDR_W-1:0]   paddr,
  input  logic [hsa_pkg::DATA_W-1:0]   pwdata,
  output logic [hsa_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hsa_pkg::CH_W-1:0]     red_in,
  input  logic [hsa_pkg::CH_W-1:0]     green_in,
  input  logic [hsa_pkg::CH_W-1:0]     blue_in,
  input  logic                         frame_end_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hsa_pkg::CH_W-1:0]     red_out,
  output logic [hsa_pkg::CH_W-1:0]     green_out,
  output logic [hsa_pkg::CH_W-1:0]     blue_out,
  output logic                         frame_end_out
);
  import hsa_pkg::*;

  logic signed [STEP_W-1:0] saturation_step;
  logic adv;

  assign pready = 1'b1;
  assign prdata = {{(DATA_W-STEP_W){1'b0}}, saturation_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation_step <= '0;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_STEP) begin
      saturation_step <= pwdata[STEP_W-1:0];
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic            v1;
  logic [CH_W-1:0] r1, g1, b1;
  logic            fe1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      r1  <= red_in;
      g1  <= green_in;
      b1  <= blue_in;
      fe1 <= frame_end_in;
    end
  end

  logic [CH_W-1:0]  mx, mn, mx_rg, mn_rg;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] denom;
  logic             gray;

  always_comb begin
    mx_rg = (g1 > r1) ? g1 : r1;
    mn_rg = (g1 < r1) ? g1 : r1;
    mx    = (b1 > mx_rg) ? b1 : mx_rg;
    mn    = (b1 < mn_rg) ? b1 : mn_rg;
    sum   = {1'b0, mx} + {1'b0, mn};
    gray  = mx == mn;
    if (gray) begin
      denom = SUM_W'(1);
    end else if (sum < SUM_W'(255)) begin
      denom = sum;
    end else begin
      denom = SUM_W'(510) - sum;
    end
  end

  logic             v2;
  side_t            s2;
  logic [CH_W-1:0]  diff2;
  logic [SUM_W-1:0] denom2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      s2     <= '{red: r1, green: g1, blue: b1, frame_end: fe1, gray: gray, sum: sum};
      diff2  <= mx - mn;
      denom2 <= denom;
    end
  end

  logic             vd1;
  logic [SAT_W-1:0] sat;
  logic [SIDE_W-1:0] sd1;

  hsa_div #(.DW(SUM_W), .QW(SAT_W), .SW(SIDE_W)) u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (v2),
    .rem_in    ({2'b00, diff2}),
    .divisor   (denom2),
    .side_in   (s2),
    .valid_out (vd1),
    .quotient  (sat),
    .side_out  (sd1)
  );

  logic [SAT_W-1:0] inc;
  logic [SAT_W:0]   inc_sat;
  logic [SAT_W-1:0] a;

  always_comb begin
    inc     = {1'b0, saturation_step[7:0], 8'b0};
    inc_sat = {1'b0, inc} + {1'b0, sat};
    if (saturation_step[STEP_W-1]) begin
      a = Q16_ONE;
    end else if (inc_sat >= {1'b0, Q16_ONE}) begin
      a = sat;
    end else begin
      a = Q16_ONE - inc;
    end
  end

  logic              v3;
  logic [SAT_W-1:0]  a3;
  logic [SIDE_W-1:0] s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= vd1;
    end
    if (adv) begin
      a3 <= a;
      s3 <= sd1;
    end
  end

  logic              vd2;
  logic [ADIV_W-1:0] quot;
  logic [SIDE_W-1:0] sd2;

  hsa_div #(.DW(SAT_W), .QW(ADIV_W), .SW(SIDE_W)) u_alpha_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (v3),
    .rem_in    ((SAT_W+1)'(256)),
    .divisor   (a3),
    .side_in   (s3),
    .valid_out (vd2),
    .quotient  (quot),
    .side_out  (sd2)
  );

  hsa_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .valid_in  (vd2),
    .quot      (quot),
    .step      (saturation_step),
    .side_in   (side_t'(sd2)),
    .valid_out (out_valid),
    .red       (red_out),
    .green     (green_out),
    .blue      (blue_out),
    .frame_end (frame_end_out)
  );

endmodule

>>> sim/hsl_saturation_adjust_test.sv
// ----------------------------------------------------------------------------
// HSL saturation adjust testbench
// Streams pixel words through the block under random sender gaps and receiver
// stalls, predicts each adjusted pixel in fixed point and compares in order.
// ----------------------------------------------------------------------------
module hsl_saturation_adjust_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hsa_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t expected_pixels[$];
    int     mismatches;
    int     step;

    function automatic logic [7:0] clamp_channel(longint v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function void note_input(pixel_t p);
      pixel_t r;
      longint ch[3];
      longint mx, mn, sum, diff, denom, sat, a, alpha, d2, num, f;
      ch[0] = p.red; ch[1] = p.green; ch[2] = p.blue;
      r = p;
      mx = ch[0]; mn = ch[0];
      for (int i = 1; i < 3; i++) begin
        if (ch[i] > mx) mx = ch[i];
        if (ch[i] < mn) mn = ch[i];
      end
      if (mx != mn) begin
        sum = mx + mn;
        diff = mx - mn;
        denom = (sum < 255) ? sum : 510 - sum;
        sat = (diff * 65536) / denom;
        for (int i = 0; i < 3; i++) begin
          d2 = 2 * ch[i] - sum;
          if (step >= 0) begin
            a = (step * 256 + sat >= 65536) ? sat : 65536 - step * 256;
            alpha = (64'sd1 << 32) / a - 65536;
            if (alpha > 16777215) alpha = 16777215;
            if (alpha < 0) alpha = 0;
            num = ch[i] * 131072 + d2 * alpha;
            ch[i] = num / 131072;
          end else begin
            f = 256 + step;
            num = sum * 256 + d2 * f;
            ch[i] = num / 512;
          end
        end
        r.red = clamp_channel(ch[0]);
        r.green = clamp_channel(ch[1]);
        r.blue = clamp_channel(ch[2]);
      end
      expected_pixels.push_back(r);
    endfunction

    function void check_result(pixel_t got);
      pixel_t e;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word: %p", got);
        return;
      end
      e = expected_pixels.pop_front();
      if (e.red !== got.red || e.green !== got.green || e.blue !== got.blue ||
          e.frame_end !== got.frame_end) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch step %0d: expected %p, got %p", step, e, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic        pready;
  logic        in_valid = 0, in_ready;
  logic [7:0]  red_in = 0, green_in = 0, blue_in = 0;
  logic        frame_end_in = 0;
  logic        out_valid, out_ready = 0;
  logic [7:0]  red_out, green_out, blue_out;
  logic        frame_end_out;

  pixel_scoreboard pixel_board = new();
  int  hold_cycles = 0;
  bit  stalls_on = 1;

  hsl_saturation_adjust u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      pixel_board.check_result('{red_out, green_out, blue_out, frame_end_out});
    if (!rst && in_valid && in_ready)
      pixel_board.note_input('{red_in, green_in, blue_in, frame_end_in});
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else if (!stalls_on) begin
      out_ready <= 1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_step(int value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= value & 32'h1FF;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    pixel_board.step = value;
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
    in_valid <= 1;
    red_in <= r; green_in <= g; blue_in <= b; frame_end_in <= fe;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pixel_board.expected_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_burst(int count);
    int left;
    left = count;
    while (left > 0) begin
      for (int k = $urandom_range(1, 20); k > 0 && left > 0; k--) begin
        if ($urandom_range(0, 4) == 0)
          send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 1));
        else begin
          int base;
          base = $urandom_range(0, 255);
          send_pixel(base, 8'(base + $urandom_range(0, 40) - 20),
                     8'(base + $urandom_range(0, 40) - 20), $urandom_range(0, 1));
        end
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    int steps[8];
    steps = '{0, 255, -256, 128, -1, 1, -128, 200};
    repeat (4) @(posedge clk);
    rst <= 0;
    write_step(255);
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 1);
    send_pixel(255, 0, 0, 0);
    send_pixel(0, 255, 0, 1);
    send_pixel(0, 0, 255, 0);
    send_pixel(128, 127, 127, 0);
    send_pixel(1, 0, 0, 1);
    send_pixel(255, 254, 254, 0);
    send_pixel(200, 100, 50, 0);
    send_pixel(10, 250, 128, 1);
    drain();
    write_step(-256);
    send_pixel(255, 0, 0, 0);
    send_pixel(170, 85, 85, 1);
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 128, 1, 1);
    drain();
    foreach (steps[s]) begin
      write_step(steps[s]);
      if (s == 3) begin
        hold_cycles = 200;
        random_burst(100);
      end else begin
        stalls_on = (s != 5);
        random_burst(70);
      end
      drain();
    end
    stalls_on = 1;
    if (pixel_board.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
